// ----- design/marker_frame_receiver_core_macros.svh -----
// Assertion macros for the marker frame receiver.
// Each macro takes a label, a clock, a reset, a condition and a consequence.
`ifndef MARKER_FRAME_RECEIVER_CORE_MACROS_SVH
`define MARKER_FRAME_RECEIVER_CORE_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define MFR_ASSERT_SAME(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("assertion failed");

// The consequence must hold in the cycle after the condition.
`define MFR_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed");

`endif

// ----- design/mfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Marker frame receiver package
// Frame layout constants, event codes, receiver state and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfr_pkg;

  localparam int FrameLen = 20;
  localparam int BodyLen  = 18;
  localparam int PayLen   = 16;
  localparam int IdxW     = 5;

  localparam logic [7:0] MarkStart = 8'hAA;
  localparam logic [7:0] MarkStop  = 8'hDD;

  localparam logic [IdxW-1:0] IdxLast   = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] IdxPayEnd = IdxW'(PayLen);

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    EV_SKIP     = 3'd0,
    EV_STORED   = 3'd1,
    EV_OK       = 3'd2,
    EV_BADSTART = 3'd3,
    EV_BADSTOP  = 3'd4,
    EV_BADSUM   = 3'd5,
    EV_LINEERR  = 3'd6,
    EV_RESYNC   = 3'd7
  } event_t;

  typedef enum logic {
    ST_HUNT,
    ST_SYNC
  } rx_state_t;

  typedef struct packed {
    event_t                ev;
    logic [7:0]            good_frames;
    logic [7:0]            desync_count;
    byte_t [PayLen-1:0]    payload;
  } mfr_result_t;

endpackage

// ----- design/mfr_if.sv -----
// ----------------------------------------------------------------------------
// Marker frame receiver channels
// Valid/ready channels for received bytes and for per-item results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface mfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  good_frames;
  logic [7:0]  desync_count;
  logic [7:0]  mode_byte;
  logic [7:0]  phase_byte;
  logic [15:0] freq_hz;
  logic [15:0] pulse_count;
  logic [15:0] wire_load;
  logic [15:0] feed_time;
  logic [15:0] hold_time;
  logic [15:0] t1_value;
  logic [15:0] t0_value;

  modport source (output valid, output event_res, output good_frames, output desync_count,
                  output mode_byte, output phase_byte, output freq_hz, output pulse_count,
                  output wire_load, output feed_time, output hold_time, output t1_value,
                  output t0_value, input ready);
  modport sink   (input valid, input event_res, input good_frames, input desync_count,
                  input mode_byte, input phase_byte, input freq_hz, input pulse_count,
                  input wire_load, input feed_time, input hold_time, input t1_value,
                  input t0_value, output ready);
endinterface

// ----- design/mfr_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted item until the frame engine consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_in_stage (
  input  logic       clk,
  input  logic       rst,
  mfr_in_if.sink     in_ch,
  input  logic       pop,
  output logic       full,
  output logic       op,
  output logic [7:0] data_byte
);
  import mfr_pkg::*;

  logic take;

  // A new item may enter whenever the register is empty or drains this cycle.
  assign in_ch.ready = !full || pop;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (take) begin
      full <= 1'b1;
    end else if (pop) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op        <= in_ch.op;
      data_byte <= byte_t'(in_ch.data_byte);
    end
  end

endmodule

// ----- design/mfr_frame_engine.sv -----
// ----------------------------------------------------------------------------
// Frame engine
// Marker hunt, frame position, checksum and held payload; one item per fire.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_frame_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                op,
  input  logic [7:0]          data_byte,
  output mfr_pkg::mfr_result_t res
);
  import mfr_pkg::*;

  rx_state_t         state;
  rx_state_t         state_next;
  logic [IdxW-1:0]   byte_index;
  logic [IdxW-1:0]   byte_index_next;
  logic [15:0]       running_sum;
  logic [15:0]       running_sum_next;
  byte_t             frame_bytes [BodyLen];
  byte_t             accepted_payload [PayLen];
  logic [7:0]        good_frame_count;
  logic [7:0]        good_frame_count_next;
  logic [7:0]        desync_total;
  logic [7:0]        desync_total_next;

  event_t            ev;
  logic              lose;
  logic              store_en;
  logic              copy_en;
  logic [IdxW-1:0]   wr_idx;
  logic [15:0]       got_sum;
  logic              last_byte;

  assign got_sum   = {frame_bytes[BodyLen-2], frame_bytes[BodyLen-1]};
  assign wr_idx    = byte_index - IdxW'(1);
  assign last_byte = (byte_index == IdxLast);

  // Next receiver state.
  always_comb begin
    state_next = state;
    if (op) begin
      state_next = ST_HUNT;
    end else begin
      case (state)
        ST_HUNT: begin
          if (data_byte == MarkStop) state_next = ST_SYNC;
        end
        ST_SYNC: begin
          if (byte_index == '0) begin
            if (data_byte != MarkStart) state_next = ST_HUNT;
          end else if (last_byte) begin
            if (data_byte != MarkStop || got_sum != running_sum) state_next = ST_HUNT;
          end
        end
        default: state_next = ST_HUNT;
      endcase
    end
  end

  // Event code, position, checksum and store controls.
  always_comb begin
    ev               = EV_SKIP;
    lose             = 1'b0;
    store_en         = 1'b0;
    copy_en          = 1'b0;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    if (op) begin
      ev   = EV_LINEERR;
      lose = 1'b1;
    end else begin
      case (state)
        ST_HUNT: begin
          if (data_byte == MarkStop) begin
            ev               = EV_RESYNC;
            byte_index_next  = '0;
            running_sum_next = '0;
          end
        end
        ST_SYNC: begin
          if (byte_index == '0) begin
            if (data_byte != MarkStart) begin
              ev   = EV_BADSTART;
              lose = 1'b1;
            end else begin
              ev               = EV_STORED;
              byte_index_next  = IdxW'(1);
              running_sum_next = '0;
            end
          end else if (!last_byte) begin
            ev              = EV_STORED;
            store_en        = 1'b1;
            byte_index_next = byte_index + IdxW'(1);
            if (byte_index <= IdxPayEnd) begin
              running_sum_next = running_sum + {8'h00, data_byte};
            end
          end else if (data_byte != MarkStop) begin
            ev   = EV_BADSTOP;
            lose = 1'b1;
          end else if (got_sum != running_sum) begin
            ev   = EV_BADSUM;
            lose = 1'b1;
          end else begin
            ev               = EV_OK;
            copy_en          = 1'b1;
            byte_index_next  = '0;
            running_sum_next = '0;
          end
        end
        default: begin
          ev   = EV_LINEERR;
          lose = 1'b1;
        end
      endcase
    end
    if (lose) begin
      byte_index_next  = '0;
      running_sum_next = '0;
    end
  end

  assign good_frame_count_next = good_frame_count + {7'd0, copy_en};
  assign desync_total_next     = desync_total + {7'd0, lose};

  // The result carries the counts and held payload as they stand after this item.
  always_comb begin
    res.ev           = ev;
    res.good_frames  = good_frame_count_next;
    res.desync_count = desync_total_next;
    for (int i = 0; i < PayLen; i++) begin
      res.payload[i] = copy_en ? frame_bytes[i] : accepted_payload[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_HUNT;
      byte_index       <= '0;
      running_sum      <= '0;
      good_frame_count <= '0;
      desync_total     <= '0;
      for (int i = 0; i < PayLen; i++) begin
        accepted_payload[i] <= '0;
      end
    end else if (fire) begin
      state            <= state_next;
      byte_index       <= byte_index_next;
      running_sum      <= running_sum_next;
      good_frame_count <= good_frame_count_next;
      desync_total     <= desync_total_next;
      if (copy_en) begin
        for (int i = 0; i < PayLen; i++) begin
          accepted_payload[i] <= frame_bytes[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_en) begin
      frame_bytes[wr_idx] <= data_byte;
    end
  end

endmodule

// ----- design/mfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// Result register
// Holds one result item and presents it on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  mfr_pkg::mfr_result_t res,
  mfr_out_if.source           res_ch
);
  import mfr_pkg::*;

  logic        valid;
  mfr_result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign res_ch.valid        = valid;
  assign res_ch.event_res    = held.ev;
  assign res_ch.good_frames  = held.good_frames;
  assign res_ch.desync_count = held.desync_count;
  assign res_ch.mode_byte    = held.payload[0];
  assign res_ch.phase_byte   = held.payload[1];
  assign res_ch.freq_hz      = {held.payload[2],  held.payload[3]};
  assign res_ch.pulse_count  = {held.payload[4],  held.payload[5]};
  assign res_ch.wire_load    = {held.payload[6],  held.payload[7]};
  assign res_ch.feed_time    = {held.payload[8],  held.payload[9]};
  assign res_ch.hold_time    = {held.payload[10], held.payload[11]};
  assign res_ch.t1_value     = {held.payload[12], held.payload[13]};
  assign res_ch.t0_value     = {held.payload[14], held.payload[15]};

endmodule

// ----- design/marker_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// Marker frame receiver core
// Path: an accepted item waits in the input register, then its result is loaded into the result register.
// Throughput: one item per cycle while results are taken, set by the frame engine step.
// The input register lets a new item enter while a result waits to be taken.
// Synchronous reset: hunting for a stop marker, counts and held payload zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "marker_frame_receiver_core_macros.svh"

module marker_frame_receiver_core (
  input  logic       clk,
  input  logic       rst,
  mfr_in_if.sink     in_ch,
  mfr_out_if.source  res_ch
);
  import mfr_pkg::*;

  logic        in_full;
  logic        in_op;
  logic [7:0]  in_byte;
  logic        advance;
  mfr_result_t res;

  // The held item moves on when the result register is empty or being emptied.
  assign advance = in_full && (!res_ch.valid || res_ch.ready);

  mfr_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .pop       (advance),
    .full      (in_full),
    .op        (in_op),
    .data_byte (in_byte)
  );

  mfr_frame_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .op        (in_op),
    .data_byte (in_byte),
    .res       (res)
  );

  mfr_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .res    (res),
    .res_ch (res_ch)
  );

  `MFR_ASSERT_NEXT(a_fire_delivers, clk, rst, advance, res_ch.valid)
  `MFR_ASSERT_SAME(a_ready_when_empty, clk, rst, !res_ch.valid, in_ch.ready)
  `MFR_ASSERT_SAME(a_no_fire_when_empty, clk, rst, !in_full, !advance)

endmodule
